// File: rtl/csfw_pkg.sv
// shared types and constants for the counting semaphore with fifo wait queue
package csfw_pkg;

  // fixed field widths
  localparam int IN_ID_W  = 8;
  localparam int COUNT_W  = 4;
  localparam int STATUS_W = 3;

  localparam logic [COUNT_W-1:0] COUNT_MAX      = '1;
  localparam logic [COUNT_W-1:0] INIT_COUNT_RST = 4'd5;

  // parameter defaults
  localparam int HOLDER_SLOTS_DEF = 8;
  localparam int WAIT_DEPTH_DEF   = 16;
  localparam int ID_BITS_DEF      = 8;

  typedef enum logic {
    OP_REQUEST = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 3'd0,
    ST_QUEUED   = 3'd1,
    ST_DROPPED  = 3'd2,
    ST_COUNT_UP = 3'd3,
    ST_HANDED   = 3'd4,
    ST_IGNORED  = 3'd5
  } status_t;

  // control from the semaphore core to the wait queue
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } waitq_ctl_t;

endpackage

// File: rtl/csfw_waitq.sv
// fifo wait queue with the oldest id held ready in a register
module csfw_waitq #(
  parameter int WAIT_DEPTH = csfw_pkg::WAIT_DEPTH_DEF,
  parameter int ID_BITS    = csfw_pkg::ID_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  csfw_pkg::waitq_ctl_t               ctl,
  input  logic [ID_BITS-1:0]                 push_id,
  output logic [$clog2(WAIT_DEPTH+1)-1:0]    fill,
  output logic [ID_BITS-1:0]                 front_id
);

  localparam int PTR_W  = $clog2(WAIT_DEPTH);
  localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WAIT_DEPTH - 1);

  logic [ID_BITS-1:0] mem [WAIT_DEPTH];
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [ID_BITS-1:0] rd_r;
  logic               push_en;
  logic               pop_en;

  assign push_en = ctl.push && !ctl.clear;
  assign pop_en  = ctl.pop && !ctl.clear;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    fill_nxt = fill_r;
    if (ctl.clear) begin
      head_nxt = '0;
      tail_nxt = '0;
      fill_nxt = '0;
    end else if (push_en) begin
      tail_nxt = (tail_r == PTR_LAST) ? '0 : tail_r + 1'b1;
      fill_nxt = fill_r + 1'b1;
    end else if (pop_en) begin
      head_nxt = (head_r == PTR_LAST) ? '0 : head_r + 1'b1;
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      fill_r <= fill_nxt;
    end
  end

  // read ahead at the next head; a push into an empty queue bypasses the array
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[tail_r] <= push_id;
    end
    if (push_en && tail_r == head_nxt) begin
      rd_r <= push_id;
    end else begin
      rd_r <= mem[head_nxt];
    end
  end

  assign fill     = fill_r;
  assign front_id = rd_r;

endmodule

// File: rtl/counting_semaphore_fifo_wait.sv
// counting semaphore top level: input register, holder table, result register
//
// Usage:
//   A request (in_op = 0) or release (in_op = 1) with in_requester_id is taken
//   at a rising edge where start is high and busy is low. busy is high only in
//   a cycle where cfg_we writes a new initial count, which restarts the
//   semaphore with that count and empties the holder table and wait queue.
//   Each request gives exactly one result via the input and result registers:
//   out_valid is high for one cycle with out_status, out_wake_valid,
//   out_wake_id and out_free_units. The receiver cannot hold results off.
//   A new request may be taken in every cycle; the holder search, the count
//   update and the queue push or pop all settle in the one execute cycle
//   between the input register and the result register, so the next request
//   already sees the updated state.
//   Reset (rst_n low at a clock edge) restores a count of 5, clears all
//   holders and the wait queue, and drops any request in flight.
module counting_semaphore_fifo_wait #(
  parameter int HOLDER_SLOTS = csfw_pkg::HOLDER_SLOTS_DEF,
  parameter int WAIT_DEPTH   = csfw_pkg::WAIT_DEPTH_DEF,
  parameter int ID_BITS      = csfw_pkg::ID_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_op,
  input  logic [csfw_pkg::IN_ID_W-1:0]      in_requester_id,
  input  logic                              cfg_we,
  input  logic [csfw_pkg::COUNT_W-1:0]      cfg_data,
  output logic                              out_valid,
  output logic [csfw_pkg::STATUS_W-1:0]     out_status,
  output logic                              out_wake_valid,
  output logic [csfw_pkg::IN_ID_W-1:0]      out_wake_id,
  output logic [csfw_pkg::COUNT_W-1:0]      out_free_units
);

  localparam int HIDX_W = (HOLDER_SLOTS > 1) ? $clog2(HOLDER_SLOTS) : 1;
  localparam int FILL_W = $clog2(WAIT_DEPTH + 1);
  localparam int EXT_W  = (ID_BITS > csfw_pkg::IN_ID_W) ? ID_BITS : csfw_pkg::IN_ID_W;

  // input register
  logic               in_vld_r;
  logic               op_r;
  logic [ID_BITS-1:0] id_r;
  logic [EXT_W-1:0]   in_id_ext;
  logic               accept;

  // semaphore state
  logic [csfw_pkg::COUNT_W-1:0] free_r, free_nxt;
  logic [HOLDER_SLOTS-1:0]      hvalid_r;
  logic [ID_BITS-1:0]           hid_r [HOLDER_SLOTS];

  // search and update
  logic              empty_found, match_found;
  logic [HIDX_W-1:0] empty_idx, match_idx;
  logic              hwr, hset, hclr;
  logic [HIDX_W-1:0] hwr_idx;
  logic [ID_BITS-1:0] hwr_id;

  csfw_pkg::waitq_ctl_t wq_ctl;
  logic [FILL_W-1:0]    wq_fill;
  logic [ID_BITS-1:0]   wq_front;
  logic [EXT_W-1:0]     wake_ext;

  // result
  csfw_pkg::status_t             status_nxt;
  logic                          wake_valid_nxt;
  logic [csfw_pkg::IN_ID_W-1:0]  wake_id_nxt;
  logic                          out_valid_r;
  logic [csfw_pkg::STATUS_W-1:0] out_status_r;
  logic                          out_wake_valid_r;
  logic [csfw_pkg::IN_ID_W-1:0]  out_wake_id_r;
  logic [csfw_pkg::COUNT_W-1:0]  out_free_units_r;

  assign busy      = cfg_we;
  assign accept    = start && !busy;
  assign in_id_ext = EXT_W'(in_requester_id);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r <= in_op;
      id_r <= in_id_ext[ID_BITS-1:0];
    end
  end

  // lowest empty slot and lowest slot held by this id
  always_comb begin
    empty_found = 1'b0;
    empty_idx   = '0;
    match_found = 1'b0;
    match_idx   = '0;
    for (int i = HOLDER_SLOTS - 1; i >= 0; i--) begin
      if (!hvalid_r[i]) begin
        empty_found = 1'b1;
        empty_idx   = HIDX_W'(i);
      end
      if (hvalid_r[i] && hid_r[i] == id_r) begin
        match_found = 1'b1;
        match_idx   = HIDX_W'(i);
      end
    end
  end

  assign wake_ext = EXT_W'(wq_front);

  always_comb begin
    status_nxt     = csfw_pkg::ST_GRANTED;
    wake_valid_nxt = 1'b0;
    wake_id_nxt    = '0;
    free_nxt       = free_r;
    hwr            = 1'b0;
    hset           = 1'b0;
    hclr           = 1'b0;
    hwr_idx        = empty_idx;
    hwr_id         = id_r;
    wq_ctl         = '0;
    wq_ctl.clear   = cfg_we;
    if (in_vld_r) begin
      if (op_r == csfw_pkg::OP_REQUEST) begin
        if (free_r != '0 && empty_found) begin
          status_nxt = csfw_pkg::ST_GRANTED;
          free_nxt   = free_r - 1'b1;
          hwr        = 1'b1;
          hset       = 1'b1;
        end else if (wq_fill < FILL_W'(WAIT_DEPTH)) begin
          status_nxt  = csfw_pkg::ST_QUEUED;
          wq_ctl.push = 1'b1;
        end else begin
          status_nxt = csfw_pkg::ST_DROPPED;
        end
      end else begin
        hwr_idx = match_idx;
        if (!match_found) begin
          status_nxt = csfw_pkg::ST_IGNORED;
        end else if (wq_fill != '0) begin
          // oldest waiter takes over the released slot
          status_nxt     = csfw_pkg::ST_HANDED;
          wq_ctl.pop     = 1'b1;
          hwr            = 1'b1;
          hwr_id         = wq_front;
          wake_valid_nxt = 1'b1;
          wake_id_nxt    = wake_ext[csfw_pkg::IN_ID_W-1:0];
        end else begin
          status_nxt = csfw_pkg::ST_COUNT_UP;
          hclr       = 1'b1;
          free_nxt   = (free_r == csfw_pkg::COUNT_MAX) ? free_r : free_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r      <= csfw_pkg::INIT_COUNT_RST;
      hvalid_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_vld_r;
      if (cfg_we) begin
        free_r   <= cfg_data;
        hvalid_r <= '0;
      end else begin
        free_r <= free_nxt;
        if (hset) begin
          hvalid_r[hwr_idx] <= 1'b1;
        end
        if (hclr) begin
          hvalid_r[hwr_idx] <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hwr && !cfg_we) begin
      hid_r[hwr_idx] <= hwr_id;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r     <= status_nxt;
    out_wake_valid_r <= wake_valid_nxt;
    out_wake_id_r    <= wake_id_nxt;
    out_free_units_r <= free_nxt;
  end

  csfw_waitq #(
    .WAIT_DEPTH (WAIT_DEPTH),
    .ID_BITS    (ID_BITS)
  ) u_waitq (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (wq_ctl),
    .push_id  (id_r),
    .fill     (wq_fill),
    .front_id (wq_front)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_wake_valid = out_wake_valid_r;
  assign out_wake_id    = out_wake_id_r;
  assign out_free_units = out_free_units_r;

endmodule

// File: rtl/csfw_checker.sv
// port-level checks for the counting semaphore, bound to the top level
module csfw_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_valid,
  input logic [csfw_pkg::STATUS_W-1:0] out_status,
  input logic                          out_wake_valid,
  input logic [csfw_pkg::IN_ID_W-1:0]  out_wake_id
);

  // every request taken gives its result through the input and result registers
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##2 out_valid)
    else $error("request taken without a result two cycles later");

  // no result without a matching request taken earlier
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without a matching request");

  // wake flag goes with the handed-over status only
  a_wake_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_wake_valid == (out_status == csfw_pkg::ST_HANDED)))
    else $error("wake flag disagrees with status");

  a_wake_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_wake_valid) |-> (out_wake_id == '0))
    else $error("wake id nonzero without a wake");

endmodule

bind counting_semaphore_fifo_wait csfw_checker u_csfw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_wake_valid (out_wake_valid),
  .out_wake_id    (out_wake_id)
);

// File: tb/tb_counting_semaphore_fifo_wait.sv
// testbench for the counting semaphore: random requests checked against a predictor
`timescale 1ns / 1ps

module tb_counting_semaphore_fifo_wait;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 7;
  localparam int SETTLE_CYCLES  = 4;
  localparam int ITEM_TARGET    = 850;
  localparam int TIMEOUT_CYCLES = 200000;
  localparam int SLOTS          = csfw_pkg::HOLDER_SLOTS_DEF;
  localparam int DEPTH          = csfw_pkg::WAIT_DEPTH_DEF;
  localparam int ID_W           = csfw_pkg::IN_ID_W;
  localparam int CNT_W          = csfw_pkg::COUNT_W;
  localparam int ST_W           = csfw_pkg::STATUS_W;

  typedef enum logic [1:0] {
    ACT_SEND,
    ACT_DRAIN,
    ACT_CONFIG
  } act_kind_t;

  typedef struct {
    act_kind_t            kind;
    csfw_pkg::op_t        op;
    logic [ID_W-1:0]      id;
    logic [CNT_W-1:0]     count;
  } act_t;

  typedef struct {
    csfw_pkg::status_t    status;
    logic                 wake_valid;
    logic [ID_W-1:0]      wake_id;
    logic [CNT_W-1:0]     free_units;
  } outcome_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  csfw_pkg::op_t        in_op = csfw_pkg::OP_REQUEST;
  logic [ID_W-1:0]      in_requester_id = '0;
  logic                 cfg_we = 1'b0;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 out_valid;
  logic [ST_W-1:0]      out_status;
  logic                 out_wake_valid;
  logic [ID_W-1:0]      out_wake_id;
  logic [CNT_W-1:0]     out_free_units;

  // semaphore state as predicted
  logic [CNT_W-1:0]     sem_free;
  logic [ID_W-1:0]      sem_holder_id [SLOTS];
  logic                 sem_holder_vld [SLOTS];
  logic [ID_W-1:0]      sem_waitq [DEPTH];
  int                   sem_wq_head;
  int                   sem_wq_tail;
  int                   sem_wq_fill;

  act_t                 act_q[$];
  outcome_t             outcome_q[$];
  int                   n_sent = 0;
  int                   n_results = 0;
  int                   n_cfg = 0;
  int                   mismatches = 0;
  int                   status_hits [6];
  int                   quiet_cycles = 0;
  int                   burst_left = 0;
  int                   gap_left = 0;

  counting_semaphore_fifo_wait u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_requester_id (in_requester_id),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_wake_valid  (out_wake_valid),
    .out_wake_id     (out_wake_id),
    .out_free_units  (out_free_units)
  );

  always begin
    #(CLK_PERIOD / 2) clk = 1'b1;
    #(CLK_PERIOD / 2) clk = 1'b0;
  end

  function automatic void sem_restart(input logic [CNT_W-1:0] count);
    sem_free = count;
    for (int i = 0; i < SLOTS; i++) begin
      sem_holder_vld[i] = 1'b0;
      sem_holder_id[i]  = '0;
    end
    sem_wq_head = 0;
    sem_wq_tail = 0;
    sem_wq_fill = 0;
  endfunction

  function automatic outcome_t sem_step(input csfw_pkg::op_t op,
                                        input logic [ID_W-1:0] id);
    int slot;
    outcome_t res;
    slot = -1;
    res = '{status: csfw_pkg::ST_GRANTED, wake_valid: 1'b0, wake_id: '0,
            free_units: '0};
    if (op == csfw_pkg::OP_REQUEST) begin
      for (int i = SLOTS - 1; i >= 0; i--)
        if (!sem_holder_vld[i]) slot = i;
      // a free unit with no empty holder slot still has to wait
      if (sem_free != 0 && slot >= 0) begin
        sem_free--;
        sem_holder_vld[slot] = 1'b1;
        sem_holder_id[slot]  = id;
        res.status = csfw_pkg::ST_GRANTED;
      end else if (sem_wq_fill < DEPTH) begin
        sem_waitq[sem_wq_tail] = id;
        sem_wq_tail = (sem_wq_tail + 1) % DEPTH;
        sem_wq_fill++;
        res.status = csfw_pkg::ST_QUEUED;
      end else begin
        res.status = csfw_pkg::ST_DROPPED;
      end
    end else begin
      for (int i = SLOTS - 1; i >= 0; i--)
        if (sem_holder_vld[i] && sem_holder_id[i] == id) slot = i;
      if (slot < 0) begin
        res.status = csfw_pkg::ST_IGNORED;
      end else if (sem_wq_fill > 0) begin
        // oldest waiter takes over the released slot
        res.wake_id = sem_waitq[sem_wq_head];
        res.wake_valid = 1'b1;
        sem_wq_head = (sem_wq_head + 1) % DEPTH;
        sem_wq_fill--;
        sem_holder_id[slot] = res.wake_id;
        res.status = csfw_pkg::ST_HANDED;
      end else begin
        sem_holder_vld[slot] = 1'b0;
        if (sem_free != csfw_pkg::COUNT_MAX) sem_free++;
        res.status = csfw_pkg::ST_COUNT_UP;
      end
    end
    res.free_units = sem_free;
    return res;
  endfunction

  task automatic add_req(input csfw_pkg::op_t op, input logic [ID_W-1:0] id);
    act_q.push_back('{kind: ACT_SEND, op: op, id: id, count: '0});
  endtask

  task automatic add_cfg(input logic [CNT_W-1:0] count);
    act_q.push_back('{kind: ACT_CONFIG, op: csfw_pkg::OP_REQUEST, id: '0, count: count});
  endtask

  task automatic add_drain();
    act_q.push_back('{kind: ACT_DRAIN, op: csfw_pkg::OP_REQUEST, id: '0, count: '0});
  endtask

  always @(posedge clk) begin : driver
    act_t head;
    logic nxt_start;
    logic nxt_we;
    nxt_start = 1'b0;
    nxt_we    = 1'b0;
    if (!rst_n) begin
      sem_restart(csfw_pkg::INIT_COUNT_RST);
      quiet_cycles = 0;
      in_op <= csfw_pkg::OP_REQUEST;
      in_requester_id <= '0;
      cfg_data <= '0;
    end else begin
      if (start && !busy) begin
        outcome_q.push_back(sem_step(in_op, in_requester_id));
        n_sent++;
      end
      if (!start && n_results == n_sent) quiet_cycles++;
      else quiet_cycles = 0;

      if (start && busy) begin
        nxt_start = 1'b1;  // request not taken yet, hold it
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (act_q.size() > 0) begin
        head = act_q[0];
        if (head.kind == ACT_SEND) begin
          void'(act_q.pop_front());
          nxt_start = 1'b1;
          in_op <= head.op;
          in_requester_id <= head.id;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else if (quiet_cycles >= SETTLE_CYCLES) begin
          void'(act_q.pop_front());
          quiet_cycles = 0;
          if (head.kind == ACT_CONFIG) begin
            nxt_we = 1'b1;
            cfg_data <= head.count;
            sem_restart(head.count);
            n_cfg++;
          end
        end
      end
    end
    start  <= nxt_start;
    cfg_we <= nxt_we;
  end

  always @(posedge clk) begin : monitor
    outcome_t exp_res;
    if (rst_n && out_valid) begin
      if (outcome_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] result with no request outstanding: %s %0d wake %0b/%0h free %0d",
                   $realtime, "status", out_status, out_wake_valid, out_wake_id,
                   out_free_units);
      end else begin
        exp_res = outcome_q.pop_front();
        n_results <= n_results + 1;
        status_hits[int'(exp_res.status)]++;
        if (out_status !== exp_res.status || out_wake_valid !== exp_res.wake_valid ||
            out_wake_id !== exp_res.wake_id || out_free_units !== exp_res.free_units) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"[%0t] mismatch: exp status %s wake %0b/%0h free %0d, ",
                      "got status %0d wake %0b/%0h free %0d"},
                     $realtime, exp_res.status.name(), exp_res.wake_valid, exp_res.wake_id,
                     exp_res.free_units, out_status, out_wake_valid, out_wake_id,
                     out_free_units);
        end
      end
    end
  end

  initial begin : stimulus
    logic [ID_W-1:0] pool [6];
    int n_items;
    int req_pct;
    int len;
    int pick;
    csfw_pkg::op_t op;
    logic [ID_W-1:0] id;
    logic [CNT_W-1:0] count;

    foreach (status_hits[i]) status_hits[i] = 0;

    // reset count: grants, repeated holder, non-holder release, releases
    add_req(csfw_pkg::OP_REQUEST, 8'h00);
    add_req(csfw_pkg::OP_REQUEST, 8'hFF);
    add_req(csfw_pkg::OP_REQUEST, 8'h00);
    add_req(csfw_pkg::OP_RELEASE, 8'h5A);
    add_req(csfw_pkg::OP_RELEASE, 8'h00);
    add_req(csfw_pkg::OP_RELEASE, 8'hFF);
    add_req(csfw_pkg::OP_RELEASE, 8'h00);
    add_drain();
    // no units: everything waits, a waiter is not a holder
    add_cfg(4'd0);
    add_req(csfw_pkg::OP_REQUEST, 8'hA5);
    add_req(csfw_pkg::OP_RELEASE, 8'hA5);
    add_req(csfw_pkg::OP_REQUEST, 8'h3C);
    // count above the slot count, then hand a slot over to a waiter
    add_cfg(csfw_pkg::COUNT_MAX);
    for (int i = 1; i <= SLOTS; i++) add_req(csfw_pkg::OP_REQUEST, ID_W'(i));
    add_req(csfw_pkg::OP_REQUEST, 8'hC3);
    add_req(csfw_pkg::OP_RELEASE, 8'h01);
    add_req(csfw_pkg::OP_RELEASE, 8'hC3);
    add_req(csfw_pkg::OP_RELEASE, 8'h02);
    n_items = 22;

    for (int phase = 0; n_items < ITEM_TARGET; phase++) begin
      if (phase % 3 == 0) begin
        pick = $urandom_range(0, 5);
        case (pick)
          0:       count = 4'd0;
          1:       count = 4'd8;
          2:       count = csfw_pkg::COUNT_MAX;
          3:       count = 4'd1;
          default: count = CNT_W'($urandom_range(0, 15));
        endcase
        add_cfg(count);
      end else if ($urandom_range(0, 3) == 0) begin
        add_drain();
      end
      // a small pool of agents per phase so releases mostly hit holders
      foreach (pool[k]) pool[k] = ID_W'($urandom_range(0, 255));
      req_pct = $urandom_range(25, 90);
      len = $urandom_range(30, 70);
      for (int j = 0; j < len; j++) begin
        op = ($urandom_range(1, 100) <= req_pct) ? csfw_pkg::OP_REQUEST
                                                 : csfw_pkg::OP_RELEASE;
        id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom_range(0, 255))
                                         : pool[$urandom_range(0, 5)];
        add_req(op, id);
        n_items++;
      end
    end

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (act_q.size() != 0 || start || n_results != n_sent) @(negedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);

    if (outcome_q.size() != 0)
      $display("%0d expected results never arrived", outcome_q.size());
    $display("checked %0d requests over %0d count settings: %0d granted, %0d queued, %0d dropped",
             n_results, n_cfg + 1, status_hits[csfw_pkg::ST_GRANTED],
             status_hits[csfw_pkg::ST_QUEUED], status_hits[csfw_pkg::ST_DROPPED]);
    $display("releases: %0d counted up, %0d handed to a waiter, %0d ignored; %0d mismatches",
             status_hits[csfw_pkg::ST_COUNT_UP], status_hits[csfw_pkg::ST_HANDED],
             status_hits[csfw_pkg::ST_IGNORED], mismatches);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("** counting_semaphore_fifo_wait: PASSED **");
    end else begin
      $display("** counting_semaphore_fifo_wait: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * TIMEOUT_CYCLES);
    $display("timeout: %0d requests sent, %0d results seen", n_sent, n_results);
    $display("** counting_semaphore_fifo_wait: FAILED **");
    $finish;
  end

endmodule

// File: counting_semaphore_fifo_wait.f
rtl/csfw_pkg.sv
rtl/csfw_waitq.sv
rtl/counting_semaphore_fifo_wait.sv
rtl/csfw_checker.sv
tb/tb_counting_semaphore_fifo_wait.sv
